@@ hw/rtl/threshold_alarm_event_logger_top_macros.svh @@
// Assertion macros for the threshold alarm event logger checker.
// Each macro expands to one labelled concurrent assertion on clk_i / rst_ni.
`ifndef THRESHOLD_ALARM_EVENT_LOGGER_TOP_MACROS_SVH
`define THRESHOLD_ALARM_EVENT_LOGGER_TOP_MACROS_SVH

// Plain property, sampled on the rising clock, quiet during reset
`define TAEL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define TAEL_ASSERT_IMP(lbl, ante, cons, msg) \
  `TAEL_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication
`define TAEL_ASSERT_NXT(lbl, ante, cons, msg) \
  `TAEL_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ hw/rtl/tael_pkg.sv @@
// Shared types and codes for the threshold alarm event logger.
// No dependencies; imported by the datapath, controller, checker and top.
`timescale 1ns / 1ps

package tael_pkg;

  // Operation codes
  localparam logic [1:0] OP_CHECK = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_BAD_INDEX   = 2'd1;
  localparam logic [1:0] STAT_BAD_CHANNEL = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_ALARM_MODE = 2'd0;
  localparam logic [1:0] CFG_THR_CH0    = 2'd1;
  localparam logic [1:0] CFG_THR_CH1    = 2'd2;
  localparam logic [1:0] CFG_THR_CH2    = 2'd3;

  localparam int unsigned NUM_THR  = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // One stored alarm record
  typedef struct packed {
    logic [31:0]        rec_time;
    logic [1:0]         rec_channel;
    logic signed [23:0] rec_threshold;
    logic signed [23:0] rec_value;
  } tael_record_t;

  // One result transaction
  typedef struct packed {
    logic [1:0]   status;
    logic         logged;
    logic         report;
    logic         wrapped;
    logic [7:0]   slot;
    logic [7:0]   record_count;
    tael_record_t rec;
  } tael_result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;      // capture the accepted input transaction
    logic exec;       // evaluate the operation and update state
    logic load_read;  // load the result from the memory read data
  } tael_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic op_read;    // latched operation is a record read
  } tael_sts_t;

endpackage

@@ hw/rtl/tael_if.sv @@
// Valid/ready channel interfaces for the input and result transactions.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps

interface tael_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [1:0]         channel;
  logic signed [23:0] sample_value;
  logic [31:0]        timestamp;
  logic [7:0]         read_index;

  modport source (output valid, op, channel, sample_value, timestamp, read_index,
                  input ready);
  modport sink   (input valid, op, channel, sample_value, timestamp, read_index,
                  output ready);
endinterface

interface tael_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               logged;
  logic               report;
  logic               wrapped;
  logic [7:0]         slot;
  logic [7:0]         record_count;
  logic [31:0]        rec_time;
  logic [1:0]         rec_channel;
  logic signed [23:0] rec_threshold;
  logic signed [23:0] rec_value;

  modport source (output valid, status, logged, report, wrapped, slot, record_count,
                         rec_time, rec_channel, rec_threshold, rec_value,
                  input ready);
  modport sink   (input valid, status, logged, report, wrapped, slot, record_count,
                        rec_time, rec_channel, rec_threshold, rec_value,
                  output ready);
endinterface

@@ hw/rtl/threshold_alarm_event_logger_top.sv @@
// Threshold alarm event logger: takes sample checks, record reads and clears,
// and returns one result transaction each. A check or a clear passes through
// the idle and execute states before the next acceptance; a record read adds
// a read state for the registered read port of the record memory. A finished
// result waits in an output register while the next transaction is accepted;
// execution of that one holds until the result is taken. The record store
// starts empty after reset and needs no clearing pass: only slots below the
// record count are ever returned. The user must write thresholds and alarm
// mode via the cfg port only while the block is idle; it is not enforced.
`timescale 1ns / 1ps

module threshold_alarm_event_logger_top
  import tael_pkg::*;
#(
  parameter int unsigned MAX_RECORDS  = 170,
  parameter int unsigned NUM_CHANNELS = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  tael_in_if.sink               in_i,
  tael_out_if.source            out_o
);

  tael_cmd_t    cmd;
  tael_sts_t    sts;
  tael_result_t result;

  tael_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tael_datapath #(
    .MAX_RECORDS  (MAX_RECORDS),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (in_i.op),
    .channel_i      (in_i.channel),
    .sample_value_i (in_i.sample_value),
    .timestamp_i    (in_i.timestamp),
    .read_index_i   (in_i.read_index),
    .result_o       (result)
  );

  // Drive the result channel payload
  assign out_o.status        = result.status;
  assign out_o.logged        = result.logged;
  assign out_o.report        = result.report;
  assign out_o.wrapped       = result.wrapped;
  assign out_o.slot          = result.slot;
  assign out_o.record_count  = result.record_count;
  assign out_o.rec_time      = result.rec.rec_time;
  assign out_o.rec_channel   = result.rec.rec_channel;
  assign out_o.rec_threshold = result.rec.rec_threshold;
  assign out_o.rec_value     = result.rec.rec_value;

endmodule

@@ hw/rtl/tael_datapath.sv @@
// Datapath: configuration registers, edge flags, record count, record memory
// and the result register. Depends on tael_pkg; driven by tael_controller.
`timescale 1ns / 1ps

module tael_datapath
  import tael_pkg::*;
#(
  parameter int unsigned MAX_RECORDS  = 170,
  parameter int unsigned NUM_CHANNELS = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  tael_cmd_t             cmd_i,
  output tael_sts_t             sts_o,
  input  logic [1:0]            op_i,
  input  logic [1:0]            channel_i,
  input  logic signed [23:0]    sample_value_i,
  input  logic [31:0]           timestamp_i,
  input  logic [7:0]            read_index_i,
  output tael_result_t          result_o
);

  localparam int unsigned IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);
  localparam int unsigned CMP_W = (CNT_W > 8) ? CNT_W : 8;
  localparam logic [2:0]  CH_LIMIT = 3'(NUM_CHANNELS);

  // Configuration
  logic               alarm_mode_q;
  logic signed [23:0] thr_q [NUM_THR];

  // Latched input transaction
  logic [1:0]         op_q;
  logic [1:0]         ch_q;
  logic signed [23:0] value_q;
  logic [31:0]        ts_q;
  logic [7:0]         ridx_q;

  // Block state
  logic [NUM_CHANNELS-1:0] was_over_q, was_over_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    rd_ok_q, rd_ok;

  // Record memory
  tael_record_t mem_q [MAX_RECORDS];
  tael_record_t rd_data_q;
  logic         wr_en;
  logic [IDX_W-1:0] wr_slot;
  logic [IDX_W-1:0] rd_addr;
  logic [CMP_W-1:0] ridx_ext;

  tael_result_t res_q, res_d, res_rd;

  logic               ch_ok;
  logic signed [23:0] thr_sel;
  logic               wo_sel;
  logic               over;
  logic               full;
  logic [CMP_W-1:0]   cnt_ext_d;
  logic [CMP_W-1:0]   cnt_ext_q;
  logic [CMP_W-1:0]   slot_ext;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_mode_q <= 1'b0;
      for (int i = 0; i < NUM_THR; i++) begin
        thr_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ALARM_MODE: alarm_mode_q <= cfg_wdata_i[0];
        CFG_THR_CH0:    thr_q[0] <= cfg_wdata_i;
        CFG_THR_CH1:    thr_q[1] <= cfg_wdata_i;
        CFG_THR_CH2:    thr_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= op_i;
      ch_q    <= channel_i;
      value_q <= sample_value_i;
      ts_q    <= timestamp_i;
      ridx_q  <= read_index_i;
    end
  end

  assign sts_o.op_read = (op_q == OP_READ);

  // Select the channel threshold and edge flag
  always_comb begin
    thr_sel = '0;
    wo_sel  = 1'b0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (ch_q == 2'(i)) begin
        thr_sel = thr_q[i];
        wo_sel  = was_over_q[i];
      end
    end
  end

  assign ch_ok    = ({1'b0, ch_q} < CH_LIMIT);
  assign over     = (value_q > thr_sel);
  assign full     = (count_q == CNT_W'(MAX_RECORDS));
  assign wr_slot  = full ? '0 : count_q[IDX_W-1:0];
  assign ridx_ext = CMP_W'(ridx_q);
  assign rd_addr  = ridx_ext[IDX_W-1:0];
  assign rd_ok    = (ridx_ext < CMP_W'(count_q));

  // Evaluate check, clear and unused operations
  always_comb begin
    res_d      = '0;
    count_d    = count_q;
    was_over_d = was_over_q;
    wr_en      = 1'b0;
    case (op_q)
      OP_CHECK: begin
        if (!ch_ok) begin
          res_d.status = STAT_BAD_CHANNEL;
        end else begin
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (ch_q == 2'(i)) begin
              was_over_d[i] = over;
            end
          end
          if (over && !wo_sel) begin
            wr_en                   = 1'b1;
            count_d                 = CNT_W'(wr_slot) + CNT_W'(1);
            res_d.logged            = 1'b1;
            res_d.report            = alarm_mode_q;
            res_d.wrapped           = full;
            res_d.rec.rec_time      = ts_q;
            res_d.rec.rec_channel   = ch_q;
            res_d.rec.rec_threshold = thr_sel;
            res_d.rec.rec_value     = value_q;
          end
        end
      end
      OP_CLEAR: count_d = '0;
      default: ;
    endcase
    slot_ext           = CMP_W'(wr_slot);
    cnt_ext_d          = CMP_W'(count_d);
    res_d.record_count = cnt_ext_d[7:0];
    if (wr_en) begin
      res_d.slot = slot_ext[7:0];
    end
  end

  // Update edge flags, count and read check
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_over_q <= '0;
      count_q    <= '0;
      rd_ok_q    <= 1'b0;
    end else if (cmd_i.exec) begin
      was_over_q <= was_over_d;
      count_q    <= count_d;
      rd_ok_q    <= rd_ok;
    end
  end

  // Record memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem_q[wr_slot] <= res_d.rec;
    end
    if (cmd_i.exec && sts_o.op_read) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Form the read result
  always_comb begin
    res_rd              = '0;
    cnt_ext_q           = CMP_W'(count_q);
    res_rd.record_count = cnt_ext_q[7:0];
    if (rd_ok_q) begin
      res_rd.slot = ridx_q;
      res_rd.rec  = rd_data_q;
    end else begin
      res_rd.status = STAT_BAD_INDEX;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && !sts_o.op_read) begin
      res_q <= res_d;
    end else if (cmd_i.load_read) begin
      res_q <= res_rd;
    end
  end

  assign result_o = res_q;

endmodule

@@ hw/rtl/tael_controller.sv @@
// Controller: sequences accept, execute and memory read, and owns the
// result valid flag. Depends on tael_pkg; commands tael_datapath.
`timescale 1ns / 1ps

module tael_controller
  import tael_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output tael_cmd_t cmd_o,
  input  tael_sts_t sts_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;
  logic   load;

  // The result register is free when empty or being taken this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // Decode commands from the current state
  always_comb begin
    cmd_o = '0;
    load  = 1'b0;
    case (state_q)
      S_IDLE: cmd_o.latch = in_valid_i;
      S_EXEC: begin
        cmd_o.exec = out_free;
        load       = out_free && !sts_i.op_read;
      end
      S_READ: begin
        cmd_o.load_read = out_free;
        load            = out_free;
      end
      default: ;
    endcase
  end

  // Advance state and hold the result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_EXEC;
        S_EXEC: begin
          if (out_free) begin
            state_q <= sts_i.op_read ? S_READ : S_IDLE;
          end
        end
        S_READ: if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/tael_checker.sv @@
// Port-level checks for the threshold alarm event logger, bound to the top.
// Depends on tael_pkg and threshold_alarm_event_logger_top_macros.svh.
`timescale 1ns / 1ps
`include "threshold_alarm_event_logger_top_macros.svh"

module tael_checker
  import tael_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] status_i,
  input logic       logged_i,
  input logic       report_i,
  input logic       wrapped_i,
  input logic [7:0] slot_i,
  input logic [7:0] record_count_i
);

  logic       stall;
  logic       rpt_seen;
  logic       wrap_seen;
  logic       log_seen;
  logic       ok_st;
  logic       first_slot;
  logic       nonempty;
  logic [9:0] held_bits;

  // Qualify result fields with the valid flag
  assign stall      = out_valid_i && !out_ready_i;
  assign rpt_seen   = out_valid_i && report_i;
  assign wrap_seen  = out_valid_i && wrapped_i;
  assign log_seen   = out_valid_i && logged_i;
  assign ok_st      = (status_i == STAT_OK);
  assign first_slot = (slot_i == 8'd0) && (record_count_i == 8'd1);
  assign nonempty   = (record_count_i != 8'd0);
  assign held_bits  = {status_i, slot_i};

  // Hold a stalled result
  `TAEL_ASSERT_NXT(a_out_hold, stall, out_valid_i && $stable(held_bits), "result not held")

  // Report only accompanies a new record
  `TAEL_ASSERT_IMP(a_report_logged, rpt_seen, logged_i && ok_st, "report without record")

  // Wrap restarts the store at slot zero with one record
  `TAEL_ASSERT_IMP(a_wrap_slot, wrap_seen, logged_i && first_slot, "wrap not at slot zero")

  // A new record leaves a non-empty store
  `TAEL_ASSERT_IMP(a_logged_count, log_seen, nonempty && ok_st, "record on empty store or error")

endmodule

bind threshold_alarm_event_logger_top tael_checker u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .status_i       (out_o.status),
  .logged_i       (out_o.logged),
  .report_i       (out_o.report),
  .wrapped_i      (out_o.wrapped),
  .slot_i         (out_o.slot),
  .record_count_i (out_o.record_count)
);
